// File: src/bpa_pkg.sv
// shared constants, codes and types of the bitmap page allocator
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    // bitmap geometry
    localparam int PAGE_COUNT = 65536;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    // page counter holds any page index and the page count itself
    localparam int PG_W       = WADDR_W + BIT_W + 1;

    // address layout
    localparam int ADDR_W     = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
    localparam int OUT_ADDR_W = 28;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ADDR_W-1:0]  LOW_LIMIT_RST  = 64'h0000_0000_0010_0000;
    localparam logic [PFN_W-1:0]   PAGE_COUNT_PFN = PFN_W'(PAGE_COUNT);
    localparam logic [PG_W-1:0]    PAGE_COUNT_PG  = PG_W'(PAGE_COUNT);
    localparam logic [PG_W-1:0]    WORD_STEP      = PG_W'(WORD_BITS);
    localparam logic [WADDR_W-1:0] LAST_WORD      = WADDR_W'(WORD_COUNT - 1);
    localparam logic [BIT_W-1:0]   LAST_BIT       = BIT_W'(WORD_BITS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END   = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC       = 2'd0,
        CMD_FREE_PAGE   = 2'd1,
        CMD_FREE_REGION = 2'd2,
        CMD_NONE        = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_OOM    = 2'd1,
        STAT_BEYOND = 2'd2
    } t_status;

    // operation of the shared bit unit
    typedef enum logic [1:0] {
        BIT_KEEP  = 2'd0,
        BIT_SET   = 2'd1,
        BIT_CLEAR = 2'd2
    } t_bit_fn;

    typedef struct packed {
        t_bit_fn          fn;
        logic [BIT_W-1:0] idx;
    } t_bit_ctl;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RANGE,
        S_A_RD,
        S_A_LOAD,
        S_A_BIT,
        S_W_RD,
        S_W_LOAD,
        S_W_BIT,
        S_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: src/bpa_ram.sv
// generic single-port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic                                   i_we,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read-first
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/bpa_bit_unit.sv
// shared bit unit: tests one bit of a bitmap word and sets or clears it
`timescale 1ns / 1ps
`default_nettype none

module bpa_bit_unit (
    input  wire logic [bpa_pkg::WORD_BITS-1:0] i_word,
    input  wire bpa_pkg::t_bit_ctl             i_ctl,
    output logic                               o_bit,
    output logic      [bpa_pkg::WORD_BITS-1:0] o_word
);

    // select the addressed bit and form the modified word
    always_comb begin
        o_bit  = i_word[i_ctl.idx];
        o_word = i_word;
        unique case (i_ctl.fn)
            bpa_pkg::BIT_KEEP: begin
                o_word = i_word;
            end
            bpa_pkg::BIT_SET: begin
                o_word[i_ctl.idx] = 1'b1;
            end
            bpa_pkg::BIT_CLEAR: begin
                o_word[i_ctl.idx] = 1'b0;
            end
            default: begin
                o_word = i_word;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/bitmap_page_allocator.sv
// top level of the bitmap page allocator: sequencer, config registers, result register
`timescale 1ns / 1ps
`default_nettype none

// First-fit page allocator over a bitmap of 65536 pages of 4 KiB, one used bit per
// page, kept as 1024 words of 64 bits in a single-port ram. After reset a clearing
// pass writes every word to all ones and the input stays stalled; configuration
// writes are taken during it. Each command is worked by one sequencer that reads
// a bitmap word, steps through its bits one per cycle in a shared bit unit and
// writes it back, so one command is in flight at a time. Allocate skips fully used
// words and then steps to the first free bit of the first word that has one;
// freeing a region walks every bitmap word that it touches. Status is 0 done,
// 1 out of memory, 2 page beyond the bitmap; page_addr is nonzero only for a
// successful allocation. The result waits in an output register, so the next
// command can be accepted while the previous result is still stalled.
module bitmap_page_allocator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic [bpa_pkg::ADDR_W-1:0]          i_byte_addr,
    input  wire logic [bpa_pkg::ADDR_W-1:0]          i_region_length,
    input  wire logic                                i_region_usable,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [bpa_pkg::OUT_ADDR_W-1:0]      o_page_addr,
    output logic      [1:0]                          o_status,
    // configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bpa_pkg::ADDR_W-1:0]          i_cfg_data
);

    // sequencer state
    bpa_pkg::t_state                 r_state, n_state;
    logic [bpa_pkg::PG_W-1:0]        r_page, n_page;
    logic [bpa_pkg::PG_W-1:0]        r_stop, n_stop;
    logic [bpa_pkg::WADDR_W-1:0]     r_waddr, n_waddr;
    logic [bpa_pkg::WORD_BITS-1:0]   r_word, n_word;
    logic                            r_chk, n_chk;
    logic [bpa_pkg::PFN_W-1:0]       r_first, n_first;
    logic [bpa_pkg::PFN_W-1:0]       r_last, n_last;
    logic                            r_empty, n_empty;
    logic [bpa_pkg::OUT_ADDR_W-1:0]  r_res_addr, n_res_addr;
    bpa_pkg::t_status                r_res_status, n_res_status;

    // captured command
    logic [1:0]                      r_cmd;
    logic [bpa_pkg::ADDR_W-1:0]      r_base;
    logic [bpa_pkg::ADDR_W-1:0]      r_len;
    logic                            r_usable;

    // configuration
    logic [bpa_pkg::ADDR_W-1:0]      r_low;
    logic [bpa_pkg::ADDR_W-1:0]      r_kst;
    logic [bpa_pkg::ADDR_W-1:0]      r_kend;

    // result register
    logic                            r_out_valid;
    logic [bpa_pkg::OUT_ADDR_W-1:0]  r_out_addr;
    bpa_pkg::t_status                r_out_status;

    // ram and bit unit
    logic [bpa_pkg::WADDR_W-1:0]     ram_addr;
    logic                            ram_we;
    logic [bpa_pkg::WORD_BITS-1:0]   ram_wdata;
    logic [bpa_pkg::WORD_BITS-1:0]   ram_rdata;
    bpa_pkg::t_bit_ctl               bu_ctl;
    logic                            bu_bit;
    logic [bpa_pkg::WORD_BITS-1:0]   bu_word;

    // helpers
    logic                            in_accept;
    logic                            out_free;
    logic [bpa_pkg::WADDR_W-1:0]     page_word;
    logic [bpa_pkg::BIT_W-1:0]       page_bit;
    logic [bpa_pkg::ADDR_W-1:0]      page_byte;
    logic                            page_skip;
    logic [bpa_pkg::PFN_W-1:0]       base_pfn;
    logic [bpa_pkg::ADDR_W:0]        region_sum;
    logic [bpa_pkg::PG_W-1:0]        stop_cap;
    logic [bpa_pkg::PG_W-1:0]        page_inc;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != bpa_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign page_word = r_page[bpa_pkg::BIT_W +: bpa_pkg::WADDR_W];
    assign page_bit  = r_page[bpa_pkg::BIT_W-1:0];
    assign page_inc  = r_page + bpa_pkg::PG_W'(1);
    assign page_byte = bpa_pkg::ADDR_W'(r_page) << bpa_pkg::PAGE_SHIFT;
    assign base_pfn  = r_base[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
    assign region_sum = {1'b0, r_base} + {1'b0, r_len};

    // region pages below the low limit or inside the kernel image stay used
    assign page_skip = r_chk && ((page_byte < r_low) ||
                                 ((page_byte >= r_kst) && (page_byte < r_kend)));

    // walk end clipped to the bitmap
    assign stop_cap = (r_last < bpa_pkg::PAGE_COUNT_PFN) ?
                      r_last[bpa_pkg::PG_W-1:0] : bpa_pkg::PAGE_COUNT_PG;

    // bitmap storage
    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (bpa_pkg::WORD_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_addr  (ram_addr),
        .i_we    (ram_we),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bpa_bit_unit u_bit_unit (
        .i_word (r_word),
        .i_ctl  (bu_ctl),
        .o_bit  (bu_bit),
        .o_word (bu_word)
    );

    assign ram_addr  = (r_state == bpa_pkg::S_WR) ? r_waddr : page_word;
    assign ram_we    = (r_state == bpa_pkg::S_WR) || (r_state == bpa_pkg::S_INIT);
    assign ram_wdata = (r_state == bpa_pkg::S_INIT) ? '1 : r_word;

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_page       = r_page;
        n_stop       = r_stop;
        n_waddr      = r_waddr;
        n_word       = r_word;
        n_chk        = r_chk;
        n_first      = r_first;
        n_last       = r_last;
        n_empty      = r_empty;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        bu_ctl.fn    = bpa_pkg::BIT_KEEP;
        bu_ctl.idx   = page_bit;

        unique case (r_state)
            bpa_pkg::S_INIT: begin
                if (page_word == bpa_pkg::LAST_WORD) begin
                    n_page  = '0;
                    n_state = bpa_pkg::S_IDLE;
                end else begin
                    n_page = r_page + bpa_pkg::WORD_STEP;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = bpa_pkg::S_DECODE;
                end
            end
            bpa_pkg::S_DECODE: begin
                n_res_addr   = '0;
                n_res_status = bpa_pkg::STAT_DONE;
                n_state      = bpa_pkg::S_DONE;
                unique case (bpa_pkg::t_cmd'(r_cmd))
                    bpa_pkg::CMD_ALLOC: begin
                        n_page  = '0;
                        n_state = bpa_pkg::S_A_RD;
                    end
                    bpa_pkg::CMD_FREE_PAGE: begin
                        if (base_pfn >= bpa_pkg::PAGE_COUNT_PFN) begin
                            n_res_status = bpa_pkg::STAT_BEYOND;
                        end else begin
                            n_page  = base_pfn[bpa_pkg::PG_W-1:0];
                            n_stop  = base_pfn[bpa_pkg::PG_W-1:0] + bpa_pkg::PG_W'(1);
                            n_chk   = 1'b0;
                            n_state = bpa_pkg::S_W_RD;
                        end
                    end
                    bpa_pkg::CMD_FREE_REGION: begin
                        if (r_usable) begin
                            // round start up, end down, saturate on overflow
                            n_first = base_pfn +
                                      bpa_pkg::PFN_W'(|r_base[bpa_pkg::PAGE_SHIFT-1:0]);
                            n_empty = (&base_pfn) && (|r_base[bpa_pkg::PAGE_SHIFT-1:0]);
                            n_last  = region_sum[bpa_pkg::ADDR_W] ? '1 :
                                      region_sum[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
                            n_chk   = 1'b1;
                            n_state = bpa_pkg::S_RANGE;
                        end
                    end
                    bpa_pkg::CMD_NONE: begin
                        n_state = bpa_pkg::S_DONE;
                    end
                    default: begin
                        n_state = bpa_pkg::S_DONE;
                    end
                endcase
            end
            bpa_pkg::S_RANGE: begin
                n_state = bpa_pkg::S_DONE;
                if (!r_empty && (r_first < r_last)) begin
                    if (r_last > bpa_pkg::PAGE_COUNT_PFN) begin
                        n_res_status = bpa_pkg::STAT_BEYOND;
                    end
                    if (r_first < bpa_pkg::PFN_W'(stop_cap)) begin
                        n_page  = r_first[bpa_pkg::PG_W-1:0];
                        n_stop  = stop_cap;
                        n_state = bpa_pkg::S_W_RD;
                    end
                end
            end
            // allocate: scan words for one that is not all ones
            bpa_pkg::S_A_RD: begin
                n_waddr = page_word;
                n_state = bpa_pkg::S_A_LOAD;
            end
            bpa_pkg::S_A_LOAD: begin
                n_word = ram_rdata;
                if (&ram_rdata) begin
                    if (r_waddr == bpa_pkg::LAST_WORD) begin
                        n_res_status = bpa_pkg::STAT_OOM;
                        n_state      = bpa_pkg::S_DONE;
                    end else begin
                        n_page  = r_page + bpa_pkg::WORD_STEP;
                        n_state = bpa_pkg::S_A_RD;
                    end
                end else begin
                    n_state = bpa_pkg::S_A_BIT;
                end
            end
            bpa_pkg::S_A_BIT: begin
                bu_ctl.fn = bpa_pkg::BIT_SET;
                if (!bu_bit) begin
                    n_word     = bu_word;
                    n_stop     = r_page;
                    n_res_addr = bpa_pkg::OUT_ADDR_W'(page_byte);
                    n_state    = bpa_pkg::S_WR;
                end else begin
                    n_page = page_inc;
                end
            end
            // walk: clear page bits word by word
            bpa_pkg::S_W_RD: begin
                n_waddr = page_word;
                n_state = bpa_pkg::S_W_LOAD;
            end
            bpa_pkg::S_W_LOAD: begin
                n_word  = ram_rdata;
                n_state = bpa_pkg::S_W_BIT;
            end
            bpa_pkg::S_W_BIT: begin
                bu_ctl.fn = page_skip ? bpa_pkg::BIT_KEEP : bpa_pkg::BIT_CLEAR;
                n_word    = bu_word;
                n_page    = page_inc;
                if ((page_inc == r_stop) || (page_bit == bpa_pkg::LAST_BIT)) begin
                    n_state = bpa_pkg::S_WR;
                end
            end
            bpa_pkg::S_WR: begin
                if (r_page == r_stop) begin
                    n_state = bpa_pkg::S_DONE;
                end else begin
                    n_state = bpa_pkg::S_W_RD;
                end
            end
            bpa_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_INIT;
            r_page  <= '0;
            r_chk   <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_page  <= n_page;
            r_chk   <= n_chk;
            r_empty <= n_empty;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_stop       <= n_stop;
        r_waddr      <= n_waddr;
        r_word       <= n_word;
        r_first      <= n_first;
        r_last       <= n_last;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= i_cmd;
            r_base   <= i_byte_addr;
            r_len    <= i_region_length;
            r_usable <= i_region_usable;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= bpa_pkg::LOW_LIMIT_RST;
            r_kst  <= '0;
            r_kend <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bpa_pkg::CFG_LOW_LIMIT:    r_low  <= i_cfg_data;
                bpa_pkg::CFG_KERNEL_START: r_kst  <= i_cfg_data;
                bpa_pkg::CFG_KERNEL_END:   r_kend <= i_cfg_data;
                default: begin
                    r_low <= r_low;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == bpa_pkg::S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bpa_pkg::S_DONE) && out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_page_addr = r_out_addr;
    assign o_status    = r_out_status;

    // a new result appears only from the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == bpa_pkg::S_DONE)
        else $error("result raised outside done state");

    // only a successful allocation carries a page address
    a_addr_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != bpa_pkg::STAT_DONE)) |-> (o_page_addr == '0))
        else $error("page address on a failed result");

    // the bitmap is not written while waiting for a command
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpa_pkg::S_IDLE) |-> !ram_we)
        else $error("bitmap write while idle");

    // a walked page always lies before the walk end
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpa_pkg::S_W_BIT) |-> (r_page < r_stop))
        else $error("walk past its end page");

    // a reported status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == bpa_pkg::STAT_DONE) ||
                         (o_status == bpa_pkg::STAT_OOM) ||
                         (o_status == bpa_pkg::STAT_BEYOND)))
        else $error("undefined status code");

endmodule

`default_nettype wire

// File: tb/page_alloc_checker.sv
// reply checker for the bitmap page allocator: tracks the bitmap and compares every reply
`timescale 1ns / 1ps

module page_alloc_checker
    import bpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [ADDR_W-1:0]     i_byte_addr,
    input  wire logic [ADDR_W-1:0]     i_region_length,
    input  wire logic                  i_region_usable,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [OUT_ADDR_W-1:0] i_page_addr,
    input  wire logic [1:0]            i_status,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ADDR_W-1:0]     i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    localparam logic [ADDR_W-1:0] PAGE_LIMIT = ADDR_W'(PAGE_COUNT);
    localparam logic [ADDR_W-1:0] PAGE_ROUND = ADDR_W'((1 << PAGE_SHIFT) - 1);
    localparam logic [ADDR_W-1:0] LAST_START = {ADDR_W{1'b1}} - PAGE_ROUND;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] page_addr;
        t_status               status;
    } t_page_reply;

    bit                page_used [PAGE_COUNT];
    logic [ADDR_W-1:0] low_limit;
    logic [ADDR_W-1:0] kern_start;
    logic [ADDR_W-1:0] kern_end;
    t_page_reply       expected_replies [$];
    t_page_reply       oldest_reply;
    int                fail_count = 0;
    int                checked = 0;

    // apply one command to the local bitmap and work out its reply
    function automatic t_page_reply predict_reply(t_cmd cmd, logic [ADDR_W-1:0] addr,
                                                  logic [ADDR_W-1:0] len, logic usable);
        t_page_reply       reply;
        logic [ADDR_W-1:0] first_pg;
        logic [ADDR_W-1:0] last_pg;
        logic [ADDR_W-1:0] stop_pg;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] pg;
        logic [ADDR_W-1:0] pg_addr;
        int                idx;
        reply.page_addr = '0;
        reply.status    = STAT_DONE;
        case (cmd)
            CMD_ALLOC: begin
                // first fit: lowest free page wins
                reply.status = STAT_OOM;
                for (idx = 0; idx < PAGE_COUNT && reply.status == STAT_OOM; idx++) begin
                    if (!page_used[idx]) begin
                        page_used[idx]  = 1'b1;
                        reply.page_addr = OUT_ADDR_W'(ADDR_W'(idx) << PAGE_SHIFT);
                        reply.status    = STAT_DONE;
                    end
                end
            end
            CMD_FREE_PAGE: begin
                pg = addr >> PAGE_SHIFT;
                if (pg >= PAGE_LIMIT) reply.status = STAT_BEYOND;
                else page_used[int'(pg)] = 1'b0;
            end
            CMD_FREE_REGION: begin
                // start rounds up, end rounds down and saturates at the top of the space
                if (usable && addr <= LAST_START) begin
                    first_pg = (addr + PAGE_ROUND) >> PAGE_SHIFT;
                    end_addr = addr + len;
                    if (end_addr < addr) end_addr = '1;
                    last_pg = end_addr >> PAGE_SHIFT;
                    if (first_pg < last_pg) begin
                        stop_pg = (last_pg < PAGE_LIMIT) ? last_pg : PAGE_LIMIT;
                        for (pg = first_pg; pg < stop_pg; pg++) begin
                            pg_addr = pg << PAGE_SHIFT;
                            if (pg_addr >= low_limit &&
                                !(pg_addr >= kern_start && pg_addr < kern_end))
                                page_used[int'(pg)] = 1'b0;
                        end
                        if (last_pg > PAGE_LIMIT) reply.status = STAT_BEYOND;
                    end
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (page_used[i]) page_used[i] = 1'b1;
            low_limit  = LOW_LIMIT_RST;
            kern_start = '0;
            kern_end   = '0;
            expected_replies.delete();
        end else begin
            // reply transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with no command pending: page_addr 0x%0h status %0d",
                           i_page_addr, i_status);
                    fail_count++;
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    checked++;
                    if (i_page_addr !== oldest_reply.page_addr) begin
                        $error("page_addr mismatch: expected 0x%0h, actual 0x%0h",
                               oldest_reply.page_addr, i_page_addr);
                        fail_count++;
                    end
                    if (i_status !== oldest_reply.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_reply.status, i_status);
                        fail_count++;
                    end
                end
            end
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOW_LIMIT:    low_limit  = i_cfg_data;
                    CFG_KERNEL_START: kern_start = i_cfg_data;
                    CFG_KERNEL_END:   kern_end   = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // command transaction
            if (i_in_valid && !i_in_stall)
                expected_replies.push_back(predict_reply(t_cmd'(i_cmd), i_byte_addr,
                                                         i_region_length, i_region_usable));
        end
        o_pending    = expected_replies.size();
        o_checked    = checked;
        o_fail_count = fail_count;
    end

endmodule

// File: tb/testbench.sv
// top of the bitmap page allocator bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import bpa_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int LOW_PAGES       = 4096;
    localparam int TIMEOUT_NS      = 25_000_000;
    localparam logic [ADDR_W-1:0] ALL_ONES     = '1;
    localparam logic [ADDR_W-1:0] BITMAP_BYTES = ADDR_W'(PAGE_COUNT) << PAGE_SHIFT;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            cmd = CMD_NONE;
    logic [ADDR_W-1:0]     byte_addr = '0;
    logic [ADDR_W-1:0]     region_length = '0;
    logic                  region_usable = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [OUT_ADDR_W-1:0] page_addr;
    logic [1:0]            status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOW_LIMIT;
    logic [ADDR_W-1:0]     cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req = 1'b0;
    int hold_offs = 0;
    int settings = 0;
    int cmd_counts [4] = '{0, 0, 0, 0};

    always #(HALF_PERIOD) clk = ~clk;

    bitmap_page_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_byte_addr     (byte_addr),
        .i_region_length (region_length),
        .i_region_usable (region_usable),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_page_addr     (page_addr),
        .o_status        (status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    page_alloc_checker reply_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_byte_addr     (byte_addr),
        .i_region_length (region_length),
        .i_region_usable (region_usable),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_page_addr     (page_addr),
        .i_status        (status),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // reply side: random stalls, plus one long hold-off on request
    always begin
        @(negedge clk);
        if (hold_off_req) begin
            out_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clk);
            hold_off_req = 1'b0;
            hold_offs++;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one command and hold it until the transaction completes
    task automatic send_cmd(input t_cmd c, input logic [ADDR_W-1:0] addr,
                            input logic [ADDR_W-1:0] len, input logic usable);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        byte_addr     <= addr;
        region_length <= len;
        region_usable <= usable;
        do @(posedge clk); while (in_stall);
        cmd_counts[int'(c)]++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] ks,
                                input logic [ADDR_W-1:0] ke);
        cfg_write(CFG_LOW_LIMIT, low);
        cfg_write(CFG_KERNEL_START, ks);
        cfg_write(CFG_KERNEL_END, ke);
        settings++;
    endtask

    // drop valid and let every outstanding reply drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // random command, biased toward the low pages so allocations find them quickly
    task automatic send_random_cmd();
        int                pick;
        int                kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        logic              usable;
        pick   = $urandom_range(0, 99);
        kind   = $urandom_range(0, 99);
        addr   = rand64();
        len    = rand64();
        usable = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            send_cmd(CMD_ALLOC, addr, len, usable);
        end else if (pick < 65) begin
            if (kind < 60)
                addr = (ADDR_W'($urandom_range(0, LOW_PAGES - 1)) << PAGE_SHIFT) |
                       ADDR_W'($urandom_range(0, 4095));
            else if (kind < 85)
                addr = (ADDR_W'($urandom_range(0, PAGE_COUNT - 1)) << PAGE_SHIFT) |
                       ADDR_W'($urandom_range(0, 4095));
            else if (kind >= 95)
                addr = BITMAP_BYTES - ADDR_W'($urandom_range(0, 1));
            send_cmd(CMD_FREE_PAGE, addr, len, usable);
        end else if (pick < 93) begin
            usable = ($urandom_range(0, 99) < 85);
            if (kind < 55) begin
                addr = ADDR_W'($urandom_range(0, LOW_PAGES - 1)) << PAGE_SHIFT;
                if ($urandom_range(0, 3) == 0) addr = addr | ADDR_W'($urandom_range(0, 4095));
                len = ADDR_W'($urandom_range(0, 64 * 4096 + 4095));
            end else if (kind < 80) begin
                addr = (ADDR_W'($urandom_range(0, PAGE_COUNT - 1)) << PAGE_SHIFT) |
                       ADDR_W'($urandom_range(0, 4095));
                len  = ADDR_W'($urandom_range(0, 16 * 4096));
            end else if (kind < 90) begin
                // straddles the end of the bitmap
                addr = (ADDR_W'(PAGE_COUNT - $urandom_range(1, 8)) << PAGE_SHIFT) |
                       ADDR_W'($urandom_range(0, 4095));
                len  = ADDR_W'($urandom_range(0, 16 * 4096));
            end
            send_cmd(CMD_FREE_REGION, addr, len, usable);
        end else begin
            send_cmd(CMD_NONE, addr, len, usable);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] ks,
                             input logic [ADDR_W-1:0] ke, input int s_pct, input int r_pct,
                             input bit pressure, input bit whole_bitmap);
        int n;
        wait_idle();
        write_config(low, ks, ke);
        sender_idle_pct = s_pct;
        recv_idle_pct   = r_pct;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (pressure && n == 20) hold_off_req = 1'b1;
            if (whole_bitmap && n == 10) send_cmd(CMD_FREE_REGION, '0, BITMAP_BYTES, 1'b1);
            send_random_cmd();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // registers go in while the bitmap is being cleared
        write_config(64'h8000, 64'h1_0000, 64'h2_0000);

        // directed: all pages used after reset
        send_cmd(CMD_ALLOC, '0, '0, 1'b0);
        send_cmd(CMD_FREE_PAGE, '0, '0, 1'b0);
        send_cmd(CMD_FREE_PAGE, '0, ALL_ONES, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, 1'b0);
        send_cmd(CMD_FREE_PAGE, 64'h1234, '0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, 1'b0);
        send_cmd(CMD_FREE_PAGE, BITMAP_BYTES, '0, 1'b0);
        send_cmd(CMD_FREE_PAGE, ALL_ONES, '0, 1'b0);
        send_cmd(CMD_FREE_PAGE, BITMAP_BYTES - 1, '0, 1'b0);
        send_cmd(CMD_ALLOC, ALL_ONES, ALL_ONES, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, 1'b0);
        // region corner cases: ignored, empty, start overflow, saturated end, bitmap edge
        send_cmd(CMD_FREE_REGION, '0, ALL_ONES, 1'b0);
        send_cmd(CMD_FREE_REGION, 64'h5000, '0, 1'b1);
        send_cmd(CMD_FREE_REGION, 64'h1, 64'hFFF, 1'b1);
        send_cmd(CMD_FREE_REGION, 64'hFFFF_FFFF_FFFF_F001, '0, 1'b1);
        send_cmd(CMD_FREE_REGION, 64'hFFFF_FFFF_FFFF_0000, ALL_ONES, 1'b1);
        send_cmd(CMD_FREE_REGION, BITMAP_BYTES - 64'h2000, 64'h4000, 1'b1);
        // low limit trims the start and kernel hole carves the middle of this one
        send_cmd(CMD_FREE_REGION, 64'h1, 64'h3_0000, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, 1'b0);
        send_cmd(CMD_NONE, ALL_ONES, ALL_ONES, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, 1'b0);

        // random phases over several register settings and idle mixes
        run_phase('0, '0, '0, 7, 88, 1'b0, 1'b0);
        run_phase(LOW_LIMIT_RST, 64'h20_0000, 64'h40_0000, 88, 7, 1'b0, 1'b0);
        run_phase(ALL_ONES, ALL_ONES, ALL_ONES, 0, 0, 1'b1, 1'b0);
        run_phase(ADDR_W'($urandom_range(0, 1 << 24)), ADDR_W'($urandom_range(0, 1 << 28)),
                  ADDR_W'($urandom_range(0, 1 << 28)), 7, 88, 1'b0, 1'b0);
        run_phase('0, '0, ALL_ONES, 88, 7, 1'b0, 1'b0);
        run_phase(64'h4000, 64'h1_0000, 64'h8_0000, 0, 0, 1'b0, 1'b1);
        wait_idle();

        $display("ran %0d commands (%0d allocate, %0d page free, %0d region free, %0d no-op)",
                 cmd_counts[0] + cmd_counts[1] + cmd_counts[2] + cmd_counts[3],
                 cmd_counts[0], cmd_counts[1], cmd_counts[2], cmd_counts[3]);
        $display("checked %0d replies over %0d register settings, %0d long reply hold-off(s)",
                 checked, settings, hold_offs);
        if (fail_count == 0 && pending == 0)
            $display("[bitmap_page_allocator] OK");
        else
            $display("[bitmap_page_allocator] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("[bitmap_page_allocator] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
src/bpa_pkg.sv
src/bpa_ram.sv
src/bpa_bit_unit.sv
src/bitmap_page_allocator.sv
tb/page_alloc_checker.sv
tb/testbench.sv
